// ----- hw/rtl/ers_pkg.sv -----
// ers_pkg: shared types and constants of the enumeration rank sort core.
// Holds the key width, the link record passed between sort cells and the
// phase encoding. No dependencies.
`default_nettype none

package ers_pkg;

  localparam int unsigned KEY_W = 32;

  typedef logic signed [KEY_W-1:0] key_t;

  // What one cell shows its neighbors.
  typedef struct packed {
    logic valid;  // cell holds a key
    logic take;   // cell is free or holds a key greater than the incoming one
    key_t key;
  } ers_link_t;

  typedef enum logic {
    PH_LOAD,
    PH_DRAIN
  } ers_phase_e;

endpackage : ers_pkg

`default_nettype wire

// ----- hw/rtl/ers_cell.sv -----
// ers_cell: one slot of the insertion chain. Keeps one key and its valid bit,
// takes a new key or its left neighbor's key on insert, and its right
// neighbor's key on a drain shift. Depends on ers_pkg.
`default_nettype none

module ers_cell (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      insert_i,  // place new_key_i into the chain
  input  wire                      shift_i,   // move every key one slot toward the head
  input  wire ers_pkg::key_t       new_key_i,
  input  wire ers_pkg::ers_link_t  left_i,    // neighbor nearer the head
  input  wire ers_pkg::ers_link_t  right_i,   // neighbor farther from the head
  output ers_pkg::ers_link_t       link_o
);
  import ers_pkg::*;

  logic valid_q, valid_d;
  key_t key_q, key_d;
  logic take;

  // Equal keys stay ahead of the newcomer, which keeps ties in arrival order.
  assign take = !valid_q || (key_q > new_key_i);

  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    if (shift_i) begin
      valid_d = right_i.valid;
      key_d   = right_i.key;
    end else if (insert_i && take) begin
      if (left_i.take) begin
        valid_d = left_i.valid;
        key_d   = left_i.key;
      end else begin
        valid_d = 1'b1;
        key_d   = new_key_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign link_o.valid = valid_q;
  assign link_o.take  = take;
  assign link_o.key   = key_q;

endmodule : ers_cell

`default_nettype wire

// ----- hw/rtl/enumeration_rank_sort_core.sv -----
// enumeration_rank_sort_core: top level of the stable rank sorter.
// Builds a chain of ers_cell slots plus the load/drain sequencer.
// Depends on ers_pkg and ers_cell.
//
//  channel | dir | tdata                      | tlast            | tuser
//  --------+-----+----------------------------+------------------+------
//  s_axis  | in  | [31:0] key_value (signed)  | last_key         | none
//  m_axis  | out | [31:0] sorted_value (signed)| last_sorted     | none
//
// Load: one key beat per cycle; each beat is inserted with the cells
//   comparing it in parallel and shifting greater keys one slot outward.
// Drain: after the beat with tlast, the chain emits its n keys from cell 0,
//   one beat per cycle while m_axis_tready_i is high, with n set by the keys
//   stored; s_axis_tready_o is low during the drain.
// A key beyond MAX_ITEMS is accepted and dropped; its tlast still starts the drain.
// Reset clears all valid bits, the count and the phase; no clearing pass.
// Output stalls hold the head cell and the whole chain.
`default_nettype none

module enumeration_rank_sort_core #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  // input key stream
  input  wire                  s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  wire ers_pkg::key_t   s_axis_tdata_i,   // [31:0] key_value
  input  wire                  s_axis_tlast_i,   // last_key
  // sorted key stream
  output logic                 m_axis_tvalid_o,
  input  wire                  m_axis_tready_i,
  output ers_pkg::key_t        m_axis_tdata_o,   // [31:0] sorted_value
  output logic                 m_axis_tlast_o    // last_sorted
);
  import ers_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_ITEMS + 1);

  ers_phase_e        phase_q, phase_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;

  logic s_beat, m_beat, full, insert, shift;

  ers_link_t links  [MAX_ITEMS];
  ers_link_t lefts  [MAX_ITEMS];
  ers_link_t rights [MAX_ITEMS];

  assign s_beat = s_axis_tvalid_i && s_axis_tready_o;
  assign m_beat = m_axis_tvalid_o && m_axis_tready_i;
  assign full   = (cnt_q == CNT_W'(MAX_ITEMS));
  assign insert = s_beat && !full;   // drop keys past capacity
  assign shift  = m_beat;

  // Chain of cells; the ends see an empty, never-taking neighbor.
  for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign lefts[g] = '{valid: 1'b0, take: 1'b0, key: '0};
    end else begin : g_mid
      assign lefts[g] = links[g-1];
    end
    if (g == MAX_ITEMS - 1) begin : g_tail
      assign rights[g] = '{valid: 1'b0, take: 1'b0, key: '0};
    end else begin : g_body
      assign rights[g] = links[g+1];
    end

    ers_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .insert_i  (insert),
      .shift_i   (shift),
      .new_key_i (s_axis_tdata_i),
      .left_i    (lefts[g]),
      .right_i   (rights[g]),
      .link_o    (links[g])
    );
  end

  // Next phase and count.
  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    case (phase_q)
      PH_LOAD: begin
        if (insert) begin
          cnt_d = cnt_q + CNT_W'(1);
        end
        if (s_beat && s_axis_tlast_i) begin
          phase_d = PH_DRAIN;
        end
      end
      PH_DRAIN: begin
        if (m_beat) begin
          cnt_d = cnt_q - CNT_W'(1);
          if (cnt_q == CNT_W'(1)) begin
            phase_d = PH_LOAD;
          end
        end
      end
      default: begin
        phase_d = PH_LOAD;
        cnt_d   = '0;
      end
    endcase
  end

  // Handshake outputs; the head cell is the output register.
  always_comb begin
    s_axis_tready_o = 1'b0;
    m_axis_tvalid_o = 1'b0;
    case (phase_q)
      PH_LOAD:  s_axis_tready_o = 1'b1;
      PH_DRAIN: m_axis_tvalid_o = 1'b1;
      default: begin
        s_axis_tready_o = 1'b0;
        m_axis_tvalid_o = 1'b0;
      end
    endcase
  end

  assign m_axis_tdata_o = links[0].key;
  assign m_axis_tlast_o = (cnt_q == CNT_W'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_LOAD;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
    end
  end

  // A drain never starts or runs with an empty chain.
  a_drain_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DRAIN) |-> (cnt_q != '0) && links[0].valid)
    else $error("drain phase with empty chain");

  // The final key beat starts the drain on the next cycle.
  a_last_starts_drain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_beat && s_axis_tlast_i) |=> m_axis_tvalid_o)
    else $error("drain did not follow the final key");

  // The flagged output beat empties the chain and reopens the input.
  a_tlast_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_beat && m_axis_tlast_o) |=> s_axis_tready_o && (cnt_q == '0) && !links[0].valid)
    else $error("chain not cleared after final sorted beat");

  // The count never passes the chain length.
  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_ITEMS))
    else $error("key count beyond capacity");

endmodule : enumeration_rank_sort_core

`default_nettype wire
